/* rtl/core/tws_pkg.sv */
// Package: shared constants, types and helpers for the toroidal window sum block.
package tws_pkg;

    // Sizing
    localparam int MAX_SIDE        = 16;
    localparam int PLANES          = 4;
    localparam int VALUE_BITS      = 16;
    localparam int SIDE_BITS       = $clog2(MAX_SIDE);
    localparam int PLANE_ADDR_BITS = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int ADDR_BITS       = PLANE_ADDR_BITS + 3 * SIDE_BITS;
    localparam int STORE_DEPTH     = PLANES * MAX_SIDE * MAX_SIDE * MAX_SIDE;

    // Fixed field widths
    localparam int REG_BITS       = 5;
    localparam int COORD_BITS     = 4;
    localparam int PLANE_BITS     = 2;
    localparam int SUM_BITS       = 28;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // Item actions
    typedef enum logic {
        ACT_STORE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GRID_X = 3'd0,
        CFG_GRID_Y = 3'd1,
        CFG_GRID_Z = 3'd2,
        CFG_WIN_X  = 3'd3,
        CFG_WIN_Y  = 3'd4,
        CFG_WIN_Z  = 3'd5
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    // Clamped grid and window sides
    typedef struct packed {
        logic [REG_BITS-1:0] gx;
        logic [REG_BITS-1:0] gy;
        logic [REG_BITS-1:0] gz;
        logic [REG_BITS-1:0] wx;
        logic [REG_BITS-1:0] wy;
        logic [REG_BITS-1:0] wz;
    } geom_t;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctrl_t;

    // Side of 0 acts as 1, above MAX_SIDE acts as MAX_SIDE
    function automatic logic [REG_BITS-1:0] clamp_side(input logic [REG_BITS-1:0] v);
        logic [REG_BITS-1:0] r;
        r = v;
        if (v == '0)
            r = REG_BITS'(1);
        else if (32'(v) > MAX_SIDE)
            r = REG_BITS'(MAX_SIDE);
        return r;
    endfunction

endpackage

/* rtl/core/tws_if.sv */
// Interfaces: item input, result output and configuration write channels.
interface tws_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [tws_pkg::PLANE_BITS-1:0]       plane;
    logic [tws_pkg::COORD_BITS-1:0]       coord_x;
    logic [tws_pkg::COORD_BITS-1:0]       coord_y;
    logic [tws_pkg::COORD_BITS-1:0]       coord_z;
    logic [tws_pkg::VALUE_BITS-1:0]       cell_value;

    modport source (output valid, action, plane, coord_x, coord_y, coord_z, cell_value,
                    input ready);
    modport sink   (input valid, action, plane, coord_x, coord_y, coord_z, cell_value,
                    output ready);
endinterface

interface tws_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [tws_pkg::SUM_BITS-1:0]         window_sum;
    logic                                 bad_position;

    modport source (output valid, window_sum, bad_position, input ready);
    modport sink   (input valid, window_sum, bad_position, output ready);
endinterface

interface tws_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tws_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [tws_pkg::REG_BITS-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/tws_ram.sv */
// Generic single-port RAM with registered read.
module tws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access a cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

/* rtl/core/tws_acc.sv */
// Shared saturating accumulator for the window sum.
module tws_acc (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tws_pkg::acc_ctrl_t             ctrl,
    input  logic [tws_pkg::VALUE_BITS-1:0] data,
    output logic [tws_pkg::SUM_BITS-1:0]   sum
);

    logic [tws_pkg::SUM_BITS-1:0] sum_reg;
    logic [tws_pkg::SUM_BITS-1:0] sum_next;
    logic [tws_pkg::SUM_BITS:0]   sum_wide;

    // Add with one guard bit, clip at the top
    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + (tws_pkg::SUM_BITS + 1)'(data);
        sum_next = sum_reg;
        if (ctrl.clear)
            sum_next = '0;
        else if (ctrl.add)
            sum_next = sum_wide[tws_pkg::SUM_BITS] ? tws_pkg::SUM_MAX
                                                   : sum_wide[tws_pkg::SUM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

/* rtl/core/tws_seq.sv */
// Sequencer: takes items, walks the wrapped window over the store, holds the result.
module tws_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    // item side
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_action,
    input  logic [tws_pkg::PLANE_BITS-1:0]      in_plane,
    input  logic [tws_pkg::COORD_BITS-1:0]      in_x,
    input  logic [tws_pkg::COORD_BITS-1:0]      in_y,
    input  logic [tws_pkg::COORD_BITS-1:0]      in_z,
    input  logic [tws_pkg::VALUE_BITS-1:0]      in_value,
    input  tws_pkg::geom_t                      geom,
    // store port
    output logic                                ram_en,
    output logic                                ram_we,
    output logic [tws_pkg::ADDR_BITS-1:0]       ram_addr,
    output logic [tws_pkg::VALUE_BITS-1:0]      ram_wdata,
    // accumulator
    output tws_pkg::acc_ctrl_t                  acc_ctrl,
    input  logic [tws_pkg::SUM_BITS-1:0]        acc_sum,
    // result side
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tws_pkg::SUM_BITS-1:0]        out_sum,
    output logic                                out_bad
);

    localparam int SB = tws_pkg::SIDE_BITS;
    localparam int RB = tws_pkg::REG_BITS;
    localparam int PB = tws_pkg::PLANE_ADDR_BITS;

    tws_pkg::seq_state_t state_reg, state_next;

    logic [PB-1:0] plane_reg, plane_next;
    logic [SB-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [SB-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [RB-1:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          bad_reg, bad_next;
    logic          out_valid_reg, out_valid_next;
    logic [tws_pkg::SUM_BITS-1:0] out_sum_reg, out_sum_next;
    logic          out_bad_reg, out_bad_next;

    logic          accept;
    logic          in_bad;
    logic          last_x, last_y, last_z;
    logic          out_load;

    // Step one coordinate round the torus
    function automatic logic [SB-1:0] wrap_inc(input logic [SB-1:0] c,
                                               input logic [RB-1:0] g);
        logic [RB-1:0] c_ext;
        c_ext = RB'(c) + RB'(1);
        return (c_ext == g) ? '0 : SB'(c_ext);
    endfunction

    // Position check on the incoming item
    always_comb
    begin
        in_bad = (RB'(in_x) >= geom.gx) || (RB'(in_y) >= geom.gy) ||
                 (RB'(in_z) >= geom.gz) || (32'(in_plane) >= tws_pkg::PLANES);
    end

    assign in_ready = (state_reg == tws_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign last_x   = (dx_reg == geom.wx - RB'(1));
    assign last_y   = (dy_reg == geom.wy - RB'(1));
    assign last_z   = (dz_reg == geom.wz - RB'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tws_pkg::ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        plane_reg   <= plane_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dz_reg      <= dz_next;
        bad_reg     <= bad_next;
        out_sum_reg <= out_sum_next;
        out_bad_reg <= out_bad_next;
    end

    // Next state, window walk and store port
    always_comb
    begin
        state_next     = state_reg;
        plane_next     = plane_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        bad_next       = bad_reg;
        rd_pend_next   = 1'b0;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = {plane_reg, z_reg, y_reg, x_reg};
        ram_wdata      = in_value;
        acc_ctrl.clear = 1'b0;
        acc_ctrl.add   = rd_pend_reg;
        out_load       = 1'b0;

        case (state_reg)
            tws_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == tws_pkg::ACT_STORE)
                    begin
                        ram_en   = !in_bad;
                        ram_we   = 1'b1;
                        ram_addr = {PB'(in_plane), SB'(in_z), SB'(in_y), SB'(in_x)};
                    end
                    else
                    begin
                        acc_ctrl.clear = 1'b1;
                        bad_next   = in_bad;
                        plane_next = PB'(in_plane);
                        bx_next    = SB'(in_x);
                        by_next    = SB'(in_y);
                        x_next     = SB'(in_x);
                        y_next     = SB'(in_y);
                        z_next     = SB'(in_z);
                        dx_next    = '0;
                        dy_next    = '0;
                        dz_next    = '0;
                        state_next = in_bad ? tws_pkg::ST_DONE : tws_pkg::ST_RUN;
                    end
                end
            end

            tws_pkg::ST_RUN:
            begin
                // one cell read a cycle
                ram_en       = 1'b1;
                rd_pend_next = 1'b1;
                if (!last_x)
                begin
                    dx_next = dx_reg + RB'(1);
                    x_next  = wrap_inc(x_reg, geom.gx);
                end
                else
                begin
                    dx_next = '0;
                    x_next  = bx_reg;
                    if (!last_y)
                    begin
                        dy_next = dy_reg + RB'(1);
                        y_next  = wrap_inc(y_reg, geom.gy);
                    end
                    else
                    begin
                        dy_next = '0;
                        y_next  = by_reg;
                        if (!last_z)
                        begin
                            dz_next = dz_reg + RB'(1);
                            z_next  = wrap_inc(z_reg, geom.gz);
                        end
                        else
                        begin
                            state_next = tws_pkg::ST_DRAIN;
                        end
                    end
                end
            end

            tws_pkg::ST_DRAIN:
            begin
                // last read lands in the accumulator
                state_next = tws_pkg::ST_DONE;
            end

            tws_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = tws_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tws_pkg::ST_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_sum_next   = out_sum_reg;
        out_bad_next   = out_bad_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_sum_next   = bad_reg ? '0 : acc_sum;
            out_bad_next   = bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_bad   = out_bad_reg;

endmodule

/* rtl/core/toroidal_window_sum.sv */
// Top level: window sum over a wrapped grid of cells kept in a RAM.
//
//  channel | dir | handshake    | payload
//  items   | in  | valid/ready  | action, plane, coord_x/y/z, cell_value
//  results | out | valid/ready  | window_sum, bad_position
//  cfg     | in  | valid/ready  | index, data (grid and window sides)
//
// A store gives no result. A query walks the window one cell a cycle
// through the single RAM port into one shared adder; a flagged query
// skips the walk and goes straight to its result.
// The result sits in an output register, so a stalled results channel only
// holds the block once a second query is done. Reset sets the side registers;
// the cell RAM is not cleared. cfg is always ready.
module toroidal_window_sum (
    input  logic      clk,
    input  logic      rst_n,
    tws_in_if.sink    items,
    tws_out_if.source results,
    tws_cfg_if.sink   cfg
);

    localparam int RB = tws_pkg::REG_BITS;

    logic [RB-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
    logic [RB-1:0] win_x_reg, win_y_reg, win_z_reg;

    tws_pkg::geom_t     geom;
    tws_pkg::acc_ctrl_t acc_ctrl;

    logic                           ram_en;
    logic                           ram_we;
    logic [tws_pkg::ADDR_BITS-1:0]  ram_addr;
    logic [tws_pkg::VALUE_BITS-1:0] ram_wdata;
    logic [tws_pkg::VALUE_BITS-1:0] ram_rdata;
    logic [tws_pkg::SUM_BITS-1:0]   acc_sum;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg <= RB'(16);
            grid_y_reg <= RB'(16);
            grid_z_reg <= RB'(1);
            win_x_reg  <= RB'(4);
            win_y_reg  <= RB'(4);
            win_z_reg  <= RB'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tws_pkg::CFG_GRID_X: grid_x_reg <= cfg.data;
                tws_pkg::CFG_GRID_Y: grid_y_reg <= cfg.data;
                tws_pkg::CFG_GRID_Z: grid_z_reg <= cfg.data;
                tws_pkg::CFG_WIN_X:  win_x_reg  <= cfg.data;
                tws_pkg::CFG_WIN_Y:  win_y_reg  <= cfg.data;
                tws_pkg::CFG_WIN_Z:  win_z_reg  <= cfg.data;
                default:             ;
            endcase
        end
    end

    // Sides as used
    always_comb
    begin
        geom.gx = tws_pkg::clamp_side(grid_x_reg);
        geom.gy = tws_pkg::clamp_side(grid_y_reg);
        geom.gz = tws_pkg::clamp_side(grid_z_reg);
        geom.wx = tws_pkg::clamp_side(win_x_reg);
        geom.wy = tws_pkg::clamp_side(win_y_reg);
        geom.wz = tws_pkg::clamp_side(win_z_reg);
    end

    tws_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .in_action (items.action),
        .in_plane  (items.plane),
        .in_x      (items.coord_x),
        .in_y      (items.coord_y),
        .in_z      (items.coord_z),
        .in_value  (items.cell_value),
        .geom      (geom),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .acc_ctrl  (acc_ctrl),
        .acc_sum   (acc_sum),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_sum   (results.window_sum),
        .out_bad   (results.bad_position)
    );

    tws_ram #(
        .WIDTH (tws_pkg::VALUE_BITS),
        .DEPTH (tws_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tws_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (acc_ctrl),
        .data  (ram_rdata),
        .sum   (acc_sum)
    );

endmodule

/* rtl/core/tws_checker.sv */
// Port checker for the toroidal window sum, bound to the top level.
module tws_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_action,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tws_pkg::SUM_BITS-1:0] out_sum,
    input logic                         out_bad
);

    // A query holds the item side until it is done
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == tws_pkg::ACT_QUERY) |=> !in_ready)
        else $error("item taken while a query is running");

    // A store never raises a result
    a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == tws_pkg::ACT_STORE) |=> !$rose(out_valid))
        else $error("result raised by a store");

    // Flagged results carry a zero sum
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_bad |-> (out_sum == '0))
        else $error("flagged result with non-zero sum");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_bad))
        else $error("stalled result changed");

endmodule

bind toroidal_window_sum tws_checker u_tws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_action (items.action),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_sum   (results.window_sum),
    .out_bad   (results.bad_position)
);
